// File: hw/rtl/dsp_pkg.sv
// Shared types, constants and helpers for the DAG store with priority topological sort.
// Depends on nothing; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package dsp_pkg;

	localparam int MAX_NODES = 32;
	localparam int PRIO_BITS = 16;
	localparam int NODE_W    = 5;
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int IN_PRIO_W = 16;
	localparam int PRIO_EXT  = (PRIO_BITS > IN_PRIO_W) ? PRIO_BITS : IN_PRIO_W;

	typedef enum logic [2:0] {
		CMD_ADD_NODE    = 3'd0,
		CMD_ADD_EDGE    = 3'd1,
		CMD_REMOVE_EDGE = 3'd2,
		CMD_INVERT_EDGE = 3'd3,
		CMD_QUERY_EDGE  = 3'd4,
		CMD_ANCESTORS   = 3'd5,
		CMD_ORDER       = 3'd6,
		CMD_ROOTS       = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_RANGE       = 3'd1,
		ST_SELF_LOOP   = 3'd2,
		ST_EDGE_EXISTS = 3'd3,
		ST_FULL        = 3'd4,
		ST_CYCLE       = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_ADD_NODE,
		OP_EDGE_RD,
		OP_EDGE_EXEC,
		OP_INV_WR,
		OP_ANC_STEP,
		OP_ROOT_STEP,
		OP_M2L_STEP,
		OP_CNT_STEP,
		OP_PICK_STEP,
		OP_PICK_DONE,
		OP_UPD,
		OP_RANGE_ERR,
		OP_EMPTY,
		OP_EMIT
	} op_t;

	typedef struct packed {
		cmd_t cmd;
		logic s_ok;
		logic sweep_last;
		logic anc_more;
		logic count_zero;
		logic found;
		logic list_empty;
		logic emit_last;
		logic out_free;
	} dp_status_t;

	function automatic logic signed [PRIO_BITS-1:0] sat_prio(
		input logic signed [IN_PRIO_W-1:0] raw);
		logic signed [PRIO_EXT-1:0] v;
		logic signed [PRIO_EXT-1:0] hi;
		logic signed [PRIO_EXT-1:0] lo;
		v  = PRIO_EXT'(raw);
		hi = $signed(PRIO_EXT'((64'd1 << (PRIO_BITS - 1)) - 64'd1));
		lo = -hi - PRIO_EXT'(1);
		if (v > hi) begin
			v = hi;
		end else if (v < lo) begin
			v = lo;
		end
		return PRIO_BITS'(v);
	endfunction

endpackage

// File: hw/rtl/dsp_ctrl.sv
// Command sequencer: one-hot state machine issuing datapath operations.
// Depends on dsp_pkg for op codes, commands and the datapath status struct.
`timescale 1ns / 1ps

module dsp_ctrl import dsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output op_t        op
);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_DISP   = 13'b0000000000010,
		S_EDGE   = 13'b0000000000100,
		S_INV    = 13'b0000000001000,
		S_ANC    = 13'b0000000010000,
		S_ROOT   = 13'b0000000100000,
		S_M2L    = 13'b0000001000000,
		S_CNT    = 13'b0000010000000,
		S_PICK   = 13'b0000100000000,
		S_PDONE  = 13'b0001000000000,
		S_UPD    = 13'b0010000000000,
		S_FINISH = 13'b0100000000000,
		S_EMIT   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		op      = OP_NONE;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (st.cmd)
					CMD_ADD_NODE: begin
						if (st.out_free) begin
							op      = OP_ADD_NODE;
							state_d = S_IDLE;
						end
					end
					CMD_ADD_EDGE, CMD_REMOVE_EDGE, CMD_INVERT_EDGE, CMD_QUERY_EDGE: begin
						op      = OP_EDGE_RD;
						state_d = S_EDGE;
					end
					CMD_ANCESTORS: begin
						if (!st.s_ok) begin
							if (st.out_free) begin
								op      = OP_RANGE_ERR;
								state_d = S_IDLE;
							end
						end else begin
							state_d = S_ANC;
						end
					end
					CMD_ORDER: state_d = st.count_zero ? S_FINISH : S_CNT;
					default:   state_d = st.count_zero ? S_FINISH : S_ROOT;
				endcase
			end
			S_EDGE: begin
				if (st.out_free) begin
					op      = OP_EDGE_EXEC;
					state_d = (st.cmd == CMD_INVERT_EDGE) ? S_INV : S_IDLE;
				end
			end
			S_INV: begin
				op      = OP_INV_WR;
				state_d = S_IDLE;
			end
			S_ANC: begin
				op = OP_ANC_STEP;
				if (st.sweep_last && !st.anc_more) begin
					state_d = S_M2L;
				end
			end
			S_ROOT: begin
				op = OP_ROOT_STEP;
				if (st.sweep_last) begin
					state_d = S_M2L;
				end
			end
			S_M2L: begin
				op = OP_M2L_STEP;
				if (st.sweep_last) begin
					state_d = S_FINISH;
				end
			end
			S_CNT: begin
				op = OP_CNT_STEP;
				if (st.sweep_last) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				op = OP_PICK_STEP;
				if (st.sweep_last) begin
					state_d = S_PDONE;
				end
			end
			S_PDONE: begin
				if (st.found) begin
					op      = OP_PICK_DONE;
					state_d = S_UPD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_UPD: begin
				op      = OP_UPD;
				state_d = S_PICK;
			end
			S_FINISH: begin
				if (st.list_empty) begin
					if (st.out_free) begin
						op      = OP_EMPTY;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					op = OP_EMIT;
					if (st.emit_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/dsp_dp.sv
// Datapath: adjacency matrix, priorities, sort scratch, result list and output register.
// Depends on dsp_pkg; driven by dsp_ctrl through op codes.
`timescale 1ns / 1ps

module dsp_dp import dsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  op_t                  op,
	input  logic [2:0]           command,
	input  logic [NODE_W-1:0]    source_node,
	input  logic [NODE_W-1:0]    target_node,
	input  logic signed [IN_PRIO_W-1:0] node_priority,
	input  logic                 out_ready,
	output dp_status_t           st,
	output logic                 out_valid,
	output logic [NODE_W-1:0]    node_index,
	output logic                 node_valid,
	output logic                 edge_present,
	output logic [2:0]           status,
	output logic                 last_result
);

	cmd_t                        cmd_q;
	logic [NODE_W-1:0]           s_q, t_q;
	logic signed [PRIO_BITS-1:0] prio_in_q;
	logic [CNT_W-1:0]            count_q;
	logic [MAX_NODES-1:0]        child_q [MAX_NODES];
	logic signed [PRIO_BITS-1:0] prio_q [MAX_NODES];
	logic [CNT_W-1:0]            pending_q [MAX_NODES];
	logic [MAX_NODES-1:0]        emitted_q;
	logic [MAX_NODES-1:0]        anc_q;
	logic                        changed_q;
	logic [NODE_W-1:0]           idx_q;
	logic [NODE_W-1:0]           best_q;
	logic signed [PRIO_BITS-1:0] best_prio_q;
	logic                        found_q;
	logic [NODE_W-1:0]           list_q [MAX_NODES];
	logic [CNT_W-1:0]            len_q;
	logic [CNT_W-1:0]            eidx_q;
	logic                        e_st_q;
	logic                        inv_go_q;
	logic                        out_valid_q;
	logic [NODE_W-1:0]           out_idx_q;
	logic                        out_nvalid_q;
	logic                        out_edge_q;
	logic [2:0]                  out_status_q;
	logic                        out_last_q;

	logic [NODE_W-1:0]    rd_addr;
	logic [MAX_NODES-1:0] row;
	logic [MAX_NODES-1:0] ready_vec;
	logic [MAX_NODES-1:0] list_mask;
	logic                 s_ok, t_ok, sweep_last, anc_hit, anc_more, pick_better;
	logic                 cyc, out_free, out_load, emit_last;
	logic [CNT_W-1:0]     total;
	logic [NODE_W-1:0]    idx_next;

	always_comb begin
		case (op)
			OP_EDGE_RD:   rd_addr = s_q;
			OP_EDGE_EXEC: rd_addr = t_q;
			OP_UPD:       rd_addr = best_q;
			default:      rd_addr = idx_q;
		endcase
	end

	assign row        = child_q[rd_addr];
	assign s_ok       = {1'b0, s_q} < count_q;
	assign t_ok       = {1'b0, t_q} < count_q;
	assign sweep_last = {1'b0, idx_q} == (count_q - CNT_W'(1));
	assign idx_next   = sweep_last ? '0 : idx_q + NODE_W'(1);
	assign anc_hit    = |(row & (anc_q | (MAX_NODES'(1) << s_q)));
	assign anc_more   = changed_q || (anc_hit && !anc_q[idx_q]);

	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) begin
			ready_vec[i] = !emitted_q[i] && (pending_q[i] == '0);
		end
	end

	assign pick_better = ready_vec[idx_q] && (!found_q || (prio_q[idx_q] < best_prio_q));
	assign list_mask   = (cmd_q == CMD_ANCESTORS) ? anc_q : ~anc_q;
	assign cyc         = (cmd_q == CMD_ORDER) && (len_q < count_q);
	assign total       = len_q + CNT_W'(cyc);
	assign emit_last   = (eidx_q + CNT_W'(1)) == total;
	assign out_free    = !out_valid_q || out_ready;
	assign out_load    = (op == OP_ADD_NODE) || (op == OP_EDGE_EXEC) ||
	                     (op == OP_RANGE_ERR) || (op == OP_EMPTY) || (op == OP_EMIT);

	assign st.cmd        = cmd_q;
	assign st.s_ok       = s_ok;
	assign st.sweep_last = sweep_last;
	assign st.anc_more   = anc_more;
	assign st.count_zero = (count_q == '0);
	assign st.found      = found_q;
	assign st.list_empty = (total == '0);
	assign st.emit_last  = emit_last;
	assign st.out_free   = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			emitted_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_NODES; i++) begin
				child_q[i]   <= '0;
				pending_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (op)
				OP_LOAD: begin
					if (cmd_t'(command) == CMD_ORDER) begin
						emitted_q <= '0;
						for (int i = 0; i < MAX_NODES; i++) begin
							pending_q[i] <= '0;
						end
					end
				end
				OP_ADD_NODE: begin
					if (count_q != CNT_W'(MAX_NODES)) begin
						child_q[count_q[NODE_W-1:0]] <= '0;
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_EDGE_EXEC: begin
					if (s_ok && t_ok) begin
						case (cmd_q)
							CMD_ADD_EDGE: begin
								if (s_q != t_q && !e_st_q) begin
									child_q[s_q][t_q] <= 1'b1;
								end
							end
							CMD_REMOVE_EDGE: child_q[s_q][t_q] <= 1'b0;
							CMD_INVERT_EDGE: begin
								if (e_st_q && !row[s_q]) begin
									child_q[s_q][t_q] <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				OP_INV_WR: begin
					if (inv_go_q) begin
						child_q[t_q][s_q] <= 1'b1;
					end
				end
				OP_CNT_STEP: begin
					for (int c = 0; c < MAX_NODES; c++) begin
						pending_q[c] <= pending_q[c] + CNT_W'(row[c]);
					end
				end
				OP_PICK_DONE: emitted_q[best_q] <= 1'b1;
				OP_UPD: begin
					for (int c = 0; c < MAX_NODES; c++) begin
						if (row[c] && pending_q[c] != '0) begin
							pending_q[c] <= pending_q[c] - CNT_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				cmd_q     <= cmd_t'(command);
				s_q       <= source_node;
				t_q       <= target_node;
				prio_in_q <= sat_prio(node_priority);
				idx_q     <= '0;
				anc_q     <= '0;
				changed_q <= 1'b0;
				found_q   <= 1'b0;
				len_q     <= '0;
				eidx_q    <= '0;
				inv_go_q  <= 1'b0;
			end
			OP_ADD_NODE: begin
				out_edge_q <= 1'b0;
				out_last_q <= 1'b1;
				if (count_q == CNT_W'(MAX_NODES)) begin
					out_idx_q    <= '0;
					out_nvalid_q <= 1'b0;
					out_status_q <= ST_FULL;
				end else begin
					prio_q[count_q[NODE_W-1:0]] <= prio_in_q;
					out_idx_q    <= count_q[NODE_W-1:0];
					out_nvalid_q <= 1'b1;
					out_status_q <= ST_OK;
				end
			end
			OP_EDGE_RD: e_st_q <= row[t_q];
			OP_EDGE_EXEC: begin
				out_idx_q    <= '0;
				out_nvalid_q <= 1'b0;
				out_edge_q   <= 1'b0;
				out_last_q   <= 1'b1;
				out_status_q <= ST_OK;
				if (!s_ok || !t_ok) begin
					out_status_q <= ST_RANGE;
				end else begin
					case (cmd_q)
						CMD_ADD_EDGE: begin
							if (s_q == t_q) begin
								out_status_q <= ST_SELF_LOOP;
							end else if (e_st_q) begin
								out_status_q <= ST_EDGE_EXISTS;
							end
						end
						CMD_INVERT_EDGE: begin
							if (e_st_q) begin
								if (row[s_q]) begin
									out_status_q <= ST_EDGE_EXISTS;
								end else begin
									inv_go_q <= 1'b1;
								end
							end
						end
						CMD_QUERY_EDGE: out_edge_q <= e_st_q;
						default: ;
					endcase
				end
			end
			OP_ANC_STEP: begin
				if (anc_hit) begin
					anc_q[idx_q] <= 1'b1;
				end
				if (anc_hit && !anc_q[idx_q]) begin
					changed_q <= 1'b1;
				end
				if (sweep_last) begin
					changed_q <= 1'b0;
				end
				idx_q <= idx_next;
			end
			OP_ROOT_STEP: begin
				anc_q <= anc_q | row;
				idx_q <= idx_next;
			end
			OP_M2L_STEP: begin
				if (list_mask[idx_q]) begin
					list_q[len_q[NODE_W-1:0]] <= idx_q;
					len_q <= len_q + CNT_W'(1);
				end
				idx_q <= idx_next;
			end
			OP_CNT_STEP: idx_q <= idx_next;
			OP_PICK_STEP: begin
				if (pick_better) begin
					best_q      <= idx_q;
					best_prio_q <= prio_q[idx_q];
					found_q     <= 1'b1;
				end
				idx_q <= idx_next;
			end
			OP_PICK_DONE: begin
				list_q[len_q[NODE_W-1:0]] <= best_q;
				len_q <= len_q + CNT_W'(1);
			end
			OP_UPD: found_q <= 1'b0;
			OP_RANGE_ERR: begin
				out_idx_q    <= '0;
				out_nvalid_q <= 1'b0;
				out_edge_q   <= 1'b0;
				out_status_q <= ST_RANGE;
				out_last_q   <= 1'b1;
			end
			OP_EMPTY: begin
				out_idx_q    <= '0;
				out_nvalid_q <= 1'b0;
				out_edge_q   <= 1'b0;
				out_status_q <= ST_OK;
				out_last_q   <= 1'b1;
			end
			OP_EMIT: begin
				out_edge_q <= 1'b0;
				out_last_q <= emit_last;
				if (eidx_q < len_q) begin
					out_idx_q    <= list_q[eidx_q[NODE_W-1:0]];
					out_nvalid_q <= 1'b1;
					out_status_q <= ST_OK;
				end else begin
					out_idx_q    <= '0;
					out_nvalid_q <= 1'b0;
					out_status_q <= ST_CYCLE;
				end
				eidx_q <= eidx_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign node_index   = out_idx_q;
	assign node_valid   = out_nvalid_q;
	assign edge_present = out_edge_q;
	assign status       = out_status_q;
	assign last_result  = out_last_q;

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free) else $error("result word loaded over a held word");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_ADD_NODE && count_q != CNT_W'(MAX_NODES))
		|=> count_q == $past(count_q) + CNT_W'(1)) else $error("node count did not advance");

	a_pick_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_PICK_DONE) |-> (found_q && !emitted_q[best_q]))
		else $error("picked node already emitted");

endmodule

// File: hw/rtl/dag_store_priority_topo_sort.sv
// Top level: DAG store with priority-driven topological sort.
// Depends on dsp_pkg, dsp_ctrl and dsp_dp.
//
//   channel | direction | handshake           | words
//   in      | sink      | in_valid / in_ready  | command, source_node, target_node, node_priority
//   out     | source    | out_valid / out_ready | node_index, node_valid, edge_present, status,
//           |           |                     | last_result
//
// Add node: load, then write. Edge commands: load, edge read, execute; invert adds a write.
// Roots: parent-marking sweep, list sweep; ancestors: up to N + 1 backward sweeps, list sweep.
// Order: in-degree sweep, per pick a sweep (one priority read a cycle) and update; results.
// Reset clears the matrix, node count and sort scratch; priorities are written by add node.
// A held output word stalls the sequencer; one word can wait while the next is prepared.
`timescale 1ns / 1ps

module dag_store_priority_topo_sort import dsp_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  command,
	input  logic [NODE_W-1:0]           source_node,
	input  logic [NODE_W-1:0]           target_node,
	input  logic signed [IN_PRIO_W-1:0] node_priority,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [NODE_W-1:0]           node_index,
	output logic                        node_valid,
	output logic                        edge_present,
	output logic [2:0]                  status,
	output logic                        last_result
);

	op_t        op;
	dp_status_t st;

	dsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.op       (op)
	);

	dsp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.command       (command),
		.source_node   (source_node),
		.target_node   (target_node),
		.node_priority (node_priority),
		.out_ready     (out_ready),
		.st            (st),
		.out_valid     (out_valid),
		.node_index    (node_index),
		.node_valid    (node_valid),
		.edge_present  (edge_present),
		.status        (status),
		.last_result   (last_result)
	);

endmodule
